// ===== hdl/kme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kme_pkg - shared types, constants and key map for the key matrix emulator
// Item structs, command format between front and back, and the key map ROM.
// ----------------------------------------------------------------------------
package kme_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int ROWS        = 8;
  localparam int COL_W       = 4;
  localparam int ROW_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CODE_BREAK  = 8'd100;
  localparam logic [7:0] CODE_LSHIFT = 8'd42;
  localparam logic [7:0] CODE_RSHIFT = 8'd54;

  localparam logic ACTION_EVENT = 1'b0;
  localparam logic ACTION_SCAN  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [7:0]       key_code;
    logic             key_pressed;
    logic [COL_W-1:0] scan_column;
    logic [ROW_W-1:0] scan_row;
  } kme_in_t;

  typedef struct packed {
    logic column_active;
    logic cell_held;
    logic any_key_active;
    logic break_asserted;
    logic shift_held;
  } kme_out_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PRESS,
    OP_RELEASE,
    OP_CLEAR
  } kme_op_t;

  typedef enum logic [1:0] {
    FORCE_KEEP,
    FORCE_OFF,
    FORCE_ON
  } kme_force_t;

  // one classified item, front to back
  typedef struct packed {
    kme_op_t          op;
    kme_force_t       force_shift;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] scan_col;
    logic [ROW_W-1:0] scan_row;
    logic             brk;
    logic             shift;
  } kme_cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    kme_cmd_t cmd;
  } kme_head_t;

  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    kme_force_t       force_shift;
  } kme_remap_t;

  // column in bits 7:4, row in bits 3:0
  function automatic logic [7:0] keymap_rom(input logic [6:0] addr);
    logic [7:0] e;
    case (addr)
      7'd1:    e = 8'h07;
      7'd2:    e = 8'h03;
      7'd3:    e = 8'h13;
      7'd4:    e = 8'h11;
      7'd5:    e = 8'h21;
      7'd6:    e = 8'h31;
      7'd7:    e = 8'h43;
      7'd8:    e = 8'h42;
      7'd9:    e = 8'h51;
      7'd10:   e = 8'h62;
      7'd11:   e = 8'h72;
      7'd12:   e = 8'h71;
      7'd14:   e = 8'h95;
      7'd15:   e = 8'h06;
      7'd16:   e = 8'h01;
      7'd17:   e = 8'h12;
      7'd18:   e = 8'h22;
      7'd19:   e = 8'h33;
      7'd20:   e = 8'h32;
      7'd21:   e = 8'h44;
      7'd22:   e = 8'h53;
      7'd23:   e = 8'h52;
      7'd24:   e = 8'h63;
      7'd25:   e = 8'h73;
      7'd26:   e = 8'h83;
      7'd27:   e = 8'h85;
      7'd28:   e = 8'h94;
      7'd29:   e = 8'h10;
      7'd30:   e = 8'h14;
      7'd31:   e = 8'h15;
      7'd32:   e = 8'h23;
      7'd33:   e = 8'h34;
      7'd34:   e = 8'h35;
      7'd35:   e = 8'h45;
      7'd36:   e = 8'h54;
      7'd37:   e = 8'h64;
      7'd38:   e = 8'h65;
      7'd39:   e = 8'h75;
      7'd43:   e = 8'h87;
      7'd44:   e = 8'h16;
      7'd45:   e = 8'h24;
      7'd46:   e = 8'h25;
      7'd47:   e = 8'h36;
      7'd48:   e = 8'h46;
      7'd49:   e = 8'h55;
      7'd50:   e = 8'h56;
      7'd51:   e = 8'h66;
      7'd52:   e = 8'h76;
      7'd53:   e = 8'h86;
      7'd57:   e = 8'h26;
      7'd58:   e = 8'h04;
      7'd59:   e = 8'h17;
      7'd60:   e = 8'h27;
      7'd61:   e = 8'h37;
      7'd62:   e = 8'h41;
      7'd63:   e = 8'h47;
      7'd64:   e = 8'h57;
      7'd65:   e = 8'h61;
      7'd66:   e = 8'h67;
      7'd67:   e = 8'h77;
      7'd68:   e = 8'h02;
      7'd97:   e = 8'h96;
      7'd103:  e = 8'h93;
      7'd105:  e = 8'h91;
      7'd106:  e = 8'h97;
      7'd108:  e = 8'h92;
      7'd111:  e = 8'h95;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // codes whose cell moves with the shift state, forcing the emulated shift cell
  function automatic kme_remap_t shift_remap(input logic [7:0] code, input logic shift);
    kme_remap_t r;
    r = '{hit: 1'b0, col: '0, row: '0, force_shift: FORCE_KEEP};
    if (shift) begin
      case (code)
        8'd3:    r = '{1'b1, 4'd7, 3'd4, FORCE_OFF};
        8'd7:    r = '{1'b1, 4'd8, 3'd1, FORCE_OFF};
        8'd41:   r = '{1'b1, 4'd8, 3'd1, FORCE_ON};
        8'd8:    r = '{1'b1, 4'd4, 3'd3, FORCE_ON};
        8'd9:    r = '{1'b1, 4'd8, 3'd4, FORCE_ON};
        8'd10:   r = '{1'b1, 4'd5, 3'd1, FORCE_ON};
        8'd11:   r = '{1'b1, 4'd6, 3'd2, FORCE_ON};
        8'd12:   r = '{1'b1, 4'd8, 3'd2, FORCE_OFF};
        8'd13:   r = '{1'b1, 4'd7, 3'd5, FORCE_ON};
        8'd39:   r = '{1'b1, 4'd8, 3'd4, FORCE_OFF};
        8'd40:   r = '{1'b1, 4'd1, 3'd3, FORCE_ON};
        default: r.hit = 1'b0;
      endcase
    end else if (code == 8'd13) begin
      r = '{1'b1, 4'd7, 3'd1, FORCE_ON};
    end
    return r;
  endfunction

endpackage

// ===== hdl/kme_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kme_front - event classifier
// Tracks shift and break flags, maps key codes to matrix cells and pushes
// one command per accepted beat into the queue.
// ----------------------------------------------------------------------------
module kme_front #(
  parameter int COLUMNS = kme_pkg::COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kme_pkg::kme_in_t  in_data,
  input  logic              q_full,
  output logic              push,
  output kme_pkg::kme_cmd_t push_cmd
);

  logic lshift_r, lshift_nxt;
  logic rshift_r, rshift_nxt;
  logic brk_r, brk_nxt;

  logic [7:0]                entry;
  logic [kme_pkg::COL_W-1:0] rom_col;
  logic [kme_pkg::ROW_W-1:0] rom_row;
  logic                      shift;
  kme_pkg::kme_remap_t       remap;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    brk_nxt    = brk_r;
    if (in_data.action == kme_pkg::ACTION_EVENT) begin
      if (in_data.key_code == kme_pkg::CODE_BREAK) begin
        brk_nxt = in_data.key_pressed;
      end else begin
        if (in_data.key_code == kme_pkg::CODE_LSHIFT) lshift_nxt = in_data.key_pressed;
        if (in_data.key_code == kme_pkg::CODE_RSHIFT) rshift_nxt = in_data.key_pressed;
      end
    end
    shift = lshift_nxt | rshift_nxt;

    // codes above the rom read as an empty entry
    entry   = in_data.key_code[7] ? 8'h00 : kme_pkg::keymap_rom(in_data.key_code[6:0]);
    rom_col = entry[7:4];
    rom_row = entry[2:0];
    if ({1'b0, rom_col} >= 5'(COLUMNS)) rom_col = '0;
    if (entry[3]) rom_row = '0;

    remap = kme_pkg::shift_remap(in_data.key_code, shift);

    push_cmd.scan_col    = in_data.scan_column;
    push_cmd.scan_row    = in_data.scan_row;
    push_cmd.brk         = brk_nxt;
    push_cmd.shift       = shift;
    push_cmd.col         = rom_col;
    push_cmd.row         = rom_row;
    push_cmd.force_shift = kme_pkg::FORCE_KEEP;
    if (remap.hit) begin
      push_cmd.col         = ({1'b0, remap.col} >= 5'(COLUMNS)) ? '0 : remap.col;
      push_cmd.row         = remap.row;
      push_cmd.force_shift = remap.force_shift;
    end

    if (in_data.action != kme_pkg::ACTION_EVENT ||
        in_data.key_code == kme_pkg::CODE_BREAK) begin
      push_cmd.op = kme_pkg::OP_NONE;
    end else if (in_data.key_pressed) begin
      push_cmd.op = kme_pkg::OP_PRESS;
    end else if (in_data.key_code == kme_pkg::CODE_LSHIFT ||
                 in_data.key_code == kme_pkg::CODE_RSHIFT) begin
      // shift release wipes the whole matrix
      push_cmd.op = kme_pkg::OP_CLEAR;
    end else begin
      push_cmd.op = kme_pkg::OP_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      brk_r    <= 1'b0;
    end else if (push) begin
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      brk_r    <= brk_nxt;
    end
  end

endmodule

// ===== hdl/kme_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kme_queue - command queue
// Two-entry fifo between the classifier and the matrix back end.
// ----------------------------------------------------------------------------
module kme_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kme_pkg::kme_cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output kme_pkg::kme_head_t head
);

  localparam int CNT_W = $clog2(kme_pkg::QUEUE_DEPTH + 1);
  localparam int PTR_W = $clog2(kme_pkg::QUEUE_DEPTH);

  kme_pkg::kme_cmd_t mem_r [kme_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNT_W'(kme_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(kme_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(kme_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not follow a pop");

endmodule

// ===== hdl/kme_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kme_back - matrix back end
// Applies queued commands to the key cell array and registers the scan
// answer taken from the updated matrix.
// ----------------------------------------------------------------------------
module kme_back #(
  parameter int COLUMNS = kme_pkg::COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kme_pkg::kme_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output kme_pkg::kme_out_t  out_data
);

  logic [kme_pkg::ROWS-1:0] cells_r   [COLUMNS];
  logic [kme_pkg::ROWS-1:0] cells_nxt [COLUMNS];
  logic [kme_pkg::ROWS-1:0] col_sel;
  logic                     any_key;
  logic                     col_act;

  logic              out_valid_r, out_valid_nxt;
  kme_pkg::kme_out_t out_data_r, out_data_nxt;

  assign pop       = head.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    col_sel = '0;
    any_key = 1'b0;
    for (int c = 0; c < COLUMNS; c++) begin
      cells_nxt[c] = cells_r[c];
      case (head.cmd.op)
        kme_pkg::OP_PRESS: begin
          // shift cell forcing comes first, the key's own cell wins
          if (c == 0 && head.cmd.force_shift == kme_pkg::FORCE_OFF) cells_nxt[c][0] = 1'b0;
          if (c == 0 && head.cmd.force_shift == kme_pkg::FORCE_ON)  cells_nxt[c][0] = 1'b1;
          if (kme_pkg::COL_W'(c) == head.cmd.col) cells_nxt[c][head.cmd.row] = 1'b1;
        end
        kme_pkg::OP_RELEASE: begin
          if (kme_pkg::COL_W'(c) == head.cmd.col) cells_nxt[c][head.cmd.row] = 1'b0;
        end
        kme_pkg::OP_CLEAR: begin
          cells_nxt[c] = '0;
        end
        default: begin
          cells_nxt[c] = cells_r[c];
        end
      endcase
      // columns past the matrix read as empty
      if (kme_pkg::COL_W'(c) == head.cmd.scan_col) col_sel = cells_nxt[c];
      any_key = any_key | (|cells_nxt[c]);
    end
    col_act = |col_sel;

    out_data_nxt.column_active  = col_act;
    out_data_nxt.cell_held      = col_act & col_sel[head.cmd.scan_row];
    out_data_nxt.any_key_active = any_key;
    out_data_nxt.break_asserted = head.cmd.brk;
    out_data_nxt.shift_held     = head.cmd.shift;

    out_valid_nxt = out_valid_r;
    if (pop)                 out_valid_nxt = 1'b1;
    else if (out_ready)      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int c = 0; c < COLUMNS; c++) cells_r[c] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        for (int c = 0; c < COLUMNS; c++) cells_r[c] <= cells_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= out_data_nxt;
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.cmd.op == kme_pkg::OP_CLEAR) |=> (out_valid_r && !out_data_r.any_key_active))
    else $error("shift release left keys in the matrix");

  a_press_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.cmd.op == kme_pkg::OP_PRESS) |=> (out_valid_r && out_data_r.any_key_active))
    else $error("key press left the matrix empty");

endmodule

// ===== hdl/key_matrix_emulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_emulator - retro keyboard matrix emulation
// Turns host key events into a 16x8 key matrix and answers scan queries.
// ----------------------------------------------------------------------------
// Every input beat is either a key event or a plain scan query, and each gives
// exactly one result beat, read at that beat's scan address from the matrix as
// it stands after the beat. The front end keeps the shift and break flags and
// maps the key code through the key map ROM; a two-entry queue hands commands
// to the back end, which updates the cell array and registers the answer. One
// item per cycle is sustained while the output is taken; a result is held
// first in its queue entry and then in the back end's output register, which
// captures the answer read from the updated cell array. Reset clears the
// matrix at once; no clearing pass is needed.
module key_matrix_emulator #(
  parameter int COLUMNS = kme_pkg::COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kme_pkg::kme_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kme_pkg::kme_out_t out_data
);

  logic               q_full;
  logic               push;
  logic               pop;
  kme_pkg::kme_cmd_t  push_cmd;
  kme_pkg::kme_head_t head;

  kme_front #(.COLUMNS(COLUMNS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  kme_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  kme_back #(.COLUMNS(COLUMNS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/key_matrix_emulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_emulator_tb - self-checking bench for the key matrix emulator
// Feeds key events and scan queries on a valid/ready stream. Each accepted
// input beat is run through a local matrix predictor, and every result beat
// is checked field by field. The run covers directed corner cases first, then
// random typing sequences and noise. Sender and receiver stall at random, and
// one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module key_matrix_emulator_tb;

  localparam int N_COLS        = 16;
  localparam int KEYMAP_DEPTH  = 128;
  localparam int PHASE_BEATS   = 400;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_BEAT  = 100;
  localparam int DRAIN_CYCLES  = 10;

  // host code -> {column, row}
  localparam logic [7:0] KEYMAP [128] = '{
    8'h00, 8'h07, 8'h03, 8'h13, 8'h11, 8'h21, 8'h31, 8'h43,
    8'h42, 8'h51, 8'h62, 8'h72, 8'h71, 8'h00, 8'h95, 8'h06,
    8'h01, 8'h12, 8'h22, 8'h33, 8'h32, 8'h44, 8'h53, 8'h52,
    8'h63, 8'h73, 8'h83, 8'h85, 8'h94, 8'h10, 8'h14, 8'h15,
    8'h23, 8'h34, 8'h35, 8'h45, 8'h54, 8'h64, 8'h65, 8'h75,
    8'h00, 8'h00, 8'h00, 8'h87, 8'h16, 8'h24, 8'h25, 8'h36,
    8'h46, 8'h55, 8'h56, 8'h66, 8'h76, 8'h86, 8'h00, 8'h00,
    8'h00, 8'h26, 8'h04, 8'h17, 8'h27, 8'h37, 8'h41, 8'h47,
    8'h57, 8'h61, 8'h67, 8'h77, 8'h02, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h96, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h93,
    8'h00, 8'h91, 8'h97, 8'h00, 8'h92, 8'h00, 8'h00, 8'h95,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // codes that move with the shift state
  localparam logic [7:0] SHIFTED_CODES [11] = '{
    8'd3, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd39, 8'd40, 8'd41
  };

  typedef struct packed {
    logic [3:0]          col;
    logic [2:0]          row;
    kme_pkg::kme_force_t frc;
  } cell_ref_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  kme_pkg::kme_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  kme_pkg::kme_out_t out_data;

  kme_pkg::kme_in_t  pending_beats [$];
  kme_pkg::kme_out_t matrix_answers [$];

  logic [7:0] model_cells [N_COLS];
  logic       lshift_q;
  logic       rshift_q;
  logic       break_q;

  int errors         = 0;
  int beats_in       = 0;
  int beats_queued   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;
  int idle_cycles    = 0;

  key_matrix_emulator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic cell_ref_t locate_key(logic [7:0] code, logic shifted);
    cell_ref_t  r;
    logic [7:0] e;
    r = '{col: '0, row: '0, frc: kme_pkg::FORCE_KEEP};
    if (code >= KEYMAP_DEPTH) return r;
    e = KEYMAP[code[6:0]];
    r.col = (int'(e[7:4]) >= N_COLS) ? 4'd0 : e[7:4];
    r.row = (e[3:0] >= 4'd8) ? 3'd0 : e[2:0];
    if (shifted) begin
      case (code)
        8'd3:    r = '{4'd7, 3'd4, kme_pkg::FORCE_OFF};
        8'd7:    r = '{4'd8, 3'd1, kme_pkg::FORCE_OFF};
        8'd41:   r = '{4'd8, 3'd1, kme_pkg::FORCE_ON};
        8'd8:    r = '{4'd4, 3'd3, kme_pkg::FORCE_ON};
        8'd9:    r = '{4'd8, 3'd4, kme_pkg::FORCE_ON};
        8'd10:   r = '{4'd5, 3'd1, kme_pkg::FORCE_ON};
        8'd11:   r = '{4'd6, 3'd2, kme_pkg::FORCE_ON};
        8'd12:   r = '{4'd8, 3'd2, kme_pkg::FORCE_OFF};
        8'd13:   r = '{4'd7, 3'd5, kme_pkg::FORCE_ON};
        8'd39:   r = '{4'd8, 3'd4, kme_pkg::FORCE_OFF};
        8'd40:   r = '{4'd1, 3'd3, kme_pkg::FORCE_ON};
        default: r.frc = kme_pkg::FORCE_KEEP;
      endcase
    end else if (code == 8'd13) begin
      r = '{4'd7, 3'd1, kme_pkg::FORCE_ON};
    end
    return r;
  endfunction

  function automatic kme_pkg::kme_out_t apply_key_beat(kme_pkg::kme_in_t b);
    cell_ref_t         c;
    kme_pkg::kme_out_t o;
    logic [7:0]        colbits;
    if (b.action == kme_pkg::ACTION_EVENT) begin
      if (b.key_code == kme_pkg::CODE_BREAK) begin
        break_q = b.key_pressed;
      end else begin
        if (b.key_code == kme_pkg::CODE_LSHIFT) lshift_q = b.key_pressed;
        if (b.key_code == kme_pkg::CODE_RSHIFT) rshift_q = b.key_pressed;
        c = locate_key(b.key_code, lshift_q | rshift_q);
        if (b.key_pressed) begin
          if (c.frc == kme_pkg::FORCE_OFF) model_cells[0][0] = 1'b0;
          if (c.frc == kme_pkg::FORCE_ON)  model_cells[0][0] = 1'b1;
          model_cells[c.col][c.row] = 1'b1;
        end else begin
          model_cells[c.col][c.row] = 1'b0;
          // letting go of either shift wipes the matrix
          if (b.key_code == kme_pkg::CODE_LSHIFT || b.key_code == kme_pkg::CODE_RSHIFT)
            foreach (model_cells[i]) model_cells[i] = '0;
        end
      end
    end
    o = '0;
    foreach (model_cells[i]) if (model_cells[i] != 0) o.any_key_active = 1'b1;
    colbits = (int'(b.scan_column) < N_COLS) ? model_cells[b.scan_column] : 8'h00;
    o.column_active  = |colbits;
    o.cell_held      = colbits[b.scan_row];
    o.break_asserted = break_q;
    o.shift_held     = lshift_q | rshift_q;
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic kme_pkg::kme_in_t key_beat(logic [7:0] code, logic pressed,
                                                logic [3:0] col, logic [2:0] row);
    kme_pkg::kme_in_t b;
    b = '{action: kme_pkg::ACTION_EVENT, key_code: code, key_pressed: pressed,
          scan_column: col, scan_row: row};
    return b;
  endfunction

  function automatic kme_pkg::kme_in_t scan_at(logic [3:0] col, logic [2:0] row);
    kme_pkg::kme_in_t b;
    b = '{action: kme_pkg::ACTION_SCAN, key_code: 8'($urandom_range(255)),
          key_pressed: 1'($urandom_range(1)), scan_column: col, scan_row: row};
    return b;
  endfunction

  // cells in use sit in columns 0..9, so lean the scan there
  function automatic logic [3:0] rand_col();
    return $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 25) return SHIFTED_CODES[$urandom_range(10)];
    if (r < 40) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(127));
  endfunction

  task automatic queue_beat(kme_pkg::kme_in_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_key(logic [7:0] code, logic pressed);
    queue_beat(key_beat(code, pressed, rand_col(), 3'($urandom_range(7))));
  endtask

  task automatic queue_scans();
    repeat ($urandom_range(1, 3)) queue_beat(scan_at(rand_col(), 3'($urandom_range(7))));
  endtask

  // press, look, release - optionally wrapped in a shift hold
  task automatic queue_typing();
    logic [7:0] code;
    logic [7:0] sh;
    bit         with_shift;
    with_shift = ($urandom_range(99) < 30);
    sh   = $urandom_range(1) ? kme_pkg::CODE_LSHIFT : kme_pkg::CODE_RSHIFT;
    code = pick_code();
    if (with_shift) queue_key(sh, 1'b1);
    queue_key(code, 1'b1);
    queue_scans();
    if ($urandom_range(99) < 85) queue_key(code, 1'b0);
    if (with_shift && $urandom_range(99) < 60) queue_key(sh, 1'b0);
  endtask

  task automatic queue_noise();
    kme_pkg::kme_in_t b;
    b.action      = 1'($urandom_range(1));
    b.key_code    = 8'($urandom_range(255));
    b.key_pressed = 1'($urandom_range(1));
    b.scan_column = 4'($urandom_range(15));
    b.scan_row    = 3'($urandom_range(7));
    queue_beat(b);
  endtask

  task automatic queue_random_mix();
    int r;
    r = $urandom_range(9);
    if (r < 7) begin
      queue_typing();
    end else if (r == 7) begin
      queue_key(kme_pkg::CODE_BREAK, 1'b1);
      queue_scans();
      queue_key(kme_pkg::CODE_BREAK, 1'b0);
    end else begin
      queue_noise();
    end
  endtask

  task automatic queue_directed();
    queue_beat(scan_at(4'd0, 3'd0));                  // empty matrix
    queue_beat(scan_at(4'd15, 3'd7));
    queue_beat(key_beat(8'd0, 1'b1, 4'd0, 3'd0));     // unused code lands on (0,0)
    queue_beat(key_beat(8'd0, 1'b0, 4'd0, 3'd0));
    queue_beat(key_beat(8'd255, 1'b1, 4'd0, 3'd0));   // beyond the key map
    queue_beat(key_beat(8'd128, 1'b0, 4'd0, 3'd0));
    queue_beat(key_beat(kme_pkg::CODE_BREAK, 1'b1, 4'd15, 3'd7));
    queue_beat(scan_at(4'd0, 3'd0));
    queue_beat(key_beat(kme_pkg::CODE_BREAK, 1'b0, 4'd0, 3'd0));
    queue_beat(key_beat(8'd106, 1'b1, 4'd9, 3'd7));   // last column in use, top row
    queue_beat(key_beat(8'd127, 1'b1, 4'd9, 3'd7));
    queue_beat(key_beat(8'd68, 1'b1, 4'd0, 3'd2));
    queue_beat(key_beat(8'd13, 1'b1, 4'd7, 3'd1));    // unshifted remap forces shift cell
    queue_beat(scan_at(4'd0, 3'd0));
    queue_beat(key_beat(kme_pkg::CODE_RSHIFT, 1'b1, 4'd7, 3'd1));
    queue_beat(key_beat(8'd13, 1'b0, 4'd7, 3'd1));    // release hits the shifted cell
    queue_beat(scan_at(4'd7, 3'd5));
    queue_beat(key_beat(8'd3, 1'b1, 4'd7, 3'd4));     // shifted remap forces shift cell off
    queue_beat(key_beat(8'd41, 1'b1, 4'd8, 3'd1));
    queue_beat(key_beat(kme_pkg::CODE_RSHIFT, 1'b0, 4'd8, 3'd1)); // wipes everything
    queue_beat(key_beat(kme_pkg::CODE_LSHIFT, 1'b1, 4'd0, 3'd0));
    queue_beat(key_beat(8'd40, 1'b1, 4'd1, 3'd3));
    queue_beat(key_beat(kme_pkg::CODE_LSHIFT, 1'b0, 4'd1, 3'd3));
    queue_beat('1);                                   // all payload bits high
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      beats_in <= 0;
      foreach (model_cells[i]) model_cells[i] = '0;
      lshift_q = 1'b0;
      rshift_q = 1'b0;
      break_q  = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        matrix_answers.push_back(apply_key_beat(in_data));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!long_hold_done && beats_in >= HOLD_AT_BEAT) begin
      // back up the block while the sender keeps offering
      long_hold_done <= 1'b1;
      hold_left      <= HOLD_CYCLES;
      out_ready      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor
  function automatic void check_field(string name, logic exp, logic got);
    if (got !== exp) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, exp, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    kme_pkg::kme_out_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (matrix_answers.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %b",
                 $time, out_data);
        errors++;
      end else begin
        exp = matrix_answers.pop_front();
        check_field("column_active", exp.column_active, out_data.column_active);
        check_field("cell_held", exp.cell_held, out_data.cell_held);
        check_field("any_key_active", exp.any_key_active, out_data.any_key_active);
        check_field("break_asserted", exp.break_asserted, out_data.break_asserted);
        check_field("shift_held", exp.shift_held, out_data.shift_held);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int target;
    queue_directed();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      target = beats_queued + PHASE_BEATS;
      while (beats_queued < target) queue_random_mix();
      while (pending_beats.size() != 0) @(posedge clk);
    end
    // let the last beat taken from the queue show up on in_valid
    @(posedge clk);
    while (in_valid || matrix_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
